// ----- rtl/maf_pkg.sv -----
package maf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int SUM_W    = 30;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REFILL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_FILL,
      ST_DIVIDE
   } state_type;

endpackage

// ----- rtl/maf_ring.sv -----
module maf_ring #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic [maf_pkg::SAMPLE_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic [maf_pkg::SAMPLE_W-1:0]      rd_data
);
   import maf_pkg::*;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/maf_divider.sv -----
module maf_divider #(
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [maf_pkg::SUM_W-1:0]     sum,
   output logic                                 done,
   output logic signed [maf_pkg::SAMPLE_W-1:0]  quotient
);
   import maf_pkg::*;

   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << SUM_W) / DEPTH);
   localparam logic [SUM_W-1:0]   DEPTH_U = SUM_W'(DEPTH);

   logic [SUM_W-1:0]    mag_in;
   logic [SUM_W-1:0]    mag_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   product_ff;
   logic                stage_ff;
   logic                done_ff;
   logic [SUM_W-1:0]    q_est;
   logic [SUM_W-1:0]    q_times_d;
   logic [SUM_W-1:0]    rem;
   logic [SUM_W-1:0]    q_fix;
   logic [SUM_W-1:0]    q_signed;
   logic signed [SAMPLE_W-1:0] quotient_ff;

   assign mag_in = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff     <= mag_in;
         neg_ff     <= sum[SUM_W-1];
         product_ff <= PROD_W'(mag_in) * PROD_W'(RECIP);
      end
   end

   always_comb begin
      q_est     = product_ff[SUM_W +: SUM_W];
      q_times_d = SUM_W'(q_est * DEPTH_U);
      rem       = mag_ff - q_times_d;
      q_fix     = (rem >= DEPTH_U) ? q_est + SUM_W'(1) : q_est;
      q_signed  = neg_ff ? SUM_W'(-q_fix) : q_fix;
   end

   always_ff @(posedge clock) begin
      if (stage_ff) begin
         quotient_ff <= q_signed[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         if (start) begin
            done_ff <= 1'b0;
         end else if (stage_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;

endmodule

// ----- rtl/moving_average_filter.sv -----
// Boxcar moving average over the last DEPTH signed 24-bit samples. A transaction with
// cmd 0 stores its sample in place of the oldest one and returns the truncated average of
// the window and the newest sample; cmd 1 arms a refill and returns the current values.
// The first sample after reset, or after a refill request, fills the whole window with
// itself. A refill request before the first sample returns 0 on both outputs. The ring
// memory read completes at the accepting edge; ST_UPDATE then updates the window sum,
// writes back and starts the reciprocal-multiply divider, which registers its product
// and then its quotient before the result loads. The input is open again in the cycle
// after the result loads, so no transaction is taken before the last one returns.
// A refilling sample writes the rest of the window one entry at a time in ST_FILL,
// via the single write port. A held result stalls the next one in ST_DIVIDE until taken.
module moving_average_filter #(
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic signed [maf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [maf_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic signed [maf_pkg::SAMPLE_W-1:0]  rsp_latest
);
   import maf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0]        LAST_IDX = PTR_W'(DEPTH - 1);
   localparam logic signed [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

   state_type state_ff, state_in;

   logic                       cmd_ff;
   logic [SAMPLE_W-1:0]        sample_ff;
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic [PTR_W-1:0]           fill_cnt_ff, fill_cnt_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0]        latest_ff, latest_in;
   logic                       refill_ff, refill_in;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_average_ff;
   logic [SAMPLE_W-1:0]        rsp_latest_ff;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       mem_wr_en;
   logic [PTR_W-1:0]           mem_wr_addr;
   logic [SAMPLE_W-1:0]        old_sample;
   logic signed [SUM_W-1:0]    s_ext;
   logic signed [SUM_W-1:0]    old_ext;
   logic                       div_start;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_quotient;
   logic                       rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s_ext      = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign old_ext    = {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};

   maf_ring #(
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (req_accept),
      .rd_addr (ptr_ff),
      .rd_data (old_sample)
   );

   maf_divider #(
      .DEPTH (DEPTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (sum_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cmd_ff == CMD_SAMPLE && refill_ff && DEPTH > 1) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_FILL: begin
            if (fill_cnt_ff == LAST_IDX) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      ptr_in      = ptr_ff;
      fill_cnt_in = fill_cnt_ff;
      sum_in      = sum_ff;
      latest_in   = latest_ff;
      refill_in   = refill_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_UPDATE: begin
            if (cmd_ff == CMD_REFILL) begin
               refill_in = 1'b1;
               div_start = 1'b1;
            end else if (refill_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               sum_in      = s_ext * DEPTH_S;
               latest_in   = sample_ff;
               ptr_in      = '0;
               fill_cnt_in = PTR_W'(1);
               refill_in   = 1'b0;
               div_start   = (DEPTH == 1);
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ptr_ff;
               sum_in      = sum_ff - old_ext + s_ext;
               latest_in   = sample_ff;
               ptr_in      = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + PTR_W'(1);
               div_start   = 1'b1;
            end
         end
         ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = fill_cnt_ff;
            fill_cnt_in = fill_cnt_ff + PTR_W'(1);
            div_start   = (fill_cnt_ff == LAST_IDX);
         end
         ST_DIVIDE: begin
            rsp_load = div_done && rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         fill_cnt_ff  <= '0;
         sum_ff       <= '0;
         latest_ff    <= '0;
         refill_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         fill_cnt_ff <= fill_cnt_in;
         sum_ff      <= sum_in;
         latest_ff   <= latest_in;
         refill_ff   <= refill_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_cmd;
         sample_ff <= req_sample;
      end
      if (rsp_load) begin
         rsp_average_ff <= div_quotient;
         rsp_latest_ff  <= latest_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_latest  = rsp_latest_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_IDX)
      else $error("write pointer out of range");

   a_fill_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (ptr_ff == '0 && !refill_ff))
      else $error("ring fill with stale pointer or armed refill");

   a_done_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && $past(state_ff) != ST_DIVIDE) |-> !div_done)
      else $error("divider result ahead of its latency");

   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPDATE))
      else $error("accepted transaction not processed");

endmodule
